// ----- hw/rtl/looper_channel_sequencer_defines.svh -----
// assertion macros for the looper channel sequencer
// used by looper_channel_sequencer.sv; needs a clk and arst_n in scope
`ifndef LOOPER_CHANNEL_SEQUENCER_DEFINES_SVH
`define LOOPER_CHANNEL_SEQUENCER_DEFINES_SVH

// same-cycle implication, checked out of reset
`define LCS_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, checked out of reset
`define LCS_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ----- hw/rtl/lcs_pkg.sv -----
// shared types, codes and constants of the looper channel sequencer
// no dependencies
`default_nettype none

package lcs_pkg;

	localparam int LCS_CHANNELS = 16;

	// midi constants
	localparam logic [1:0] CMD_CONTROL = 2'd1;
	localparam logic [1:0] CMD_NOTE    = 2'd2;
	localparam logic [4:0] MIDI_CH_CTRL = 5'd16;
	localparam logic [6:0] CC_SUSTAIN   = 7'd64;
	localparam logic [6:0] NOTE_RESET   = 7'd127;
	localparam logic [6:0] NOTE_LOW     = 7'd60;
	localparam logic [6:0] NOTE_HIGH    = 7'd72;
	// zero-based channels with special restart modes
	localparam int HALF_CH    = 7;
	localparam int REVERSE_CH = 8;

	typedef enum logic [2:0] {
		ACT_STOP     = 3'd0,
		ACT_PLAY     = 3'd1,
		ACT_HALF     = 3'd2,
		ACT_REVERSE  = 3'd3,
		ACT_RECORD   = 3'd4,
		ACT_SELECT_A = 3'd5
	} action_t;

	// microprogram step addresses
	typedef enum logic [2:0] {
		STEP_IDLE  = 3'd0,
		STEP_RSCAN = 3'd1,
		STEP_CLEAR = 3'd2,
		STEP_STOP  = 3'd3,
		STEP_PLAY  = 3'd4,
		STEP_REC   = 3'd5,
		STEP_SEL   = 3'd6
	} step_t;

	typedef enum logic [1:0] {
		EMIT_NONE,
		EMIT_MASK,
		EMIT_MASK_OTHER,
		EMIT_ALWAYS
	} emit_t;

	typedef enum logic [1:0] {
		ASEL_STOP,
		ASEL_PLAY,
		ASEL_RECORD,
		ASEL_SELECT
	} asel_t;

	typedef enum logic [1:0] {
		BR_NEXT,
		BR_LOOP,
		BR_DISPATCH
	} branch_t;

	typedef enum logic [1:0] {
		OP_NONE,
		OP_CLEAR,
		OP_SET_ACTIVE
	} op_t;

	typedef struct packed {
		emit_t   emit;
		asel_t   asel;
		logic    inc_j;
		logic    last;
		branch_t br;
		step_t   tgt_more;
		step_t   tgt_done;
		op_t     op;
	} ctrl_word_t;

endpackage

`default_nettype wire

// ----- hw/rtl/lcs_ucode_rom.sv -----
// control store of the looper channel sequencer: one control word per step
// depends on lcs_pkg
`default_nettype none

module lcs_ucode_rom
	import lcs_pkg::*;
(
	input  step_t      step,
	output ctrl_word_t word
);

	// emit, action, inc_j, last, branch, target while scanning, target when done, op
	always_comb begin
		unique case (step)
			STEP_IDLE: begin
				word = '{EMIT_NONE, ASEL_STOP, 1'b0, 1'b0, BR_DISPATCH,
					STEP_IDLE, STEP_IDLE, OP_NONE};
			end
			STEP_RSCAN: begin
				word = '{EMIT_MASK, ASEL_STOP, 1'b1, 1'b0, BR_LOOP,
					STEP_RSCAN, STEP_CLEAR, OP_NONE};
			end
			STEP_CLEAR: begin
				word = '{EMIT_NONE, ASEL_STOP, 1'b0, 1'b0, BR_NEXT,
					STEP_REC, STEP_REC, OP_CLEAR};
			end
			STEP_STOP: begin
				word = '{EMIT_MASK_OTHER, ASEL_STOP, 1'b0, 1'b0, BR_NEXT,
					STEP_PLAY, STEP_PLAY, OP_NONE};
			end
			STEP_PLAY: begin
				word = '{EMIT_MASK_OTHER, ASEL_PLAY, 1'b1, 1'b0, BR_LOOP,
					STEP_STOP, STEP_REC, OP_NONE};
			end
			STEP_REC: begin
				word = '{EMIT_ALWAYS, ASEL_RECORD, 1'b0, 1'b0, BR_NEXT,
					STEP_SEL, STEP_SEL, OP_SET_ACTIVE};
			end
			STEP_SEL: begin
				word = '{EMIT_ALWAYS, ASEL_SELECT, 1'b0, 1'b1, BR_NEXT,
					STEP_IDLE, STEP_IDLE, OP_NONE};
			end
			default: begin
				word = '{EMIT_NONE, ASEL_STOP, 1'b0, 1'b0, BR_NEXT,
					STEP_IDLE, STEP_IDLE, OP_NONE};
			end
		endcase
	end

endmodule

`default_nettype wire

// ----- hw/rtl/looper_channel_sequencer.sv -----
// looper channel sequencer top level: step counter, datapath and output register
// depends on lcs_pkg, lcs_ucode_rom and looper_channel_sequencer_defines.svh
`default_nettype none
`include "looper_channel_sequencer_defines.svh"

// Takes one MIDI event word at a time and emits looper command words. Notes on
// MIDI channel 16 arm a reset (note 127) or pick the pending record channel
// (notes 60 to 71) and emit nothing. A sustain pedal press runs a microprogram
// from a small control store: with a reset armed it scans all CHANNELS
// channels, stopping the looping ones, then clears the looping mask; otherwise
// it steps through each channel with a stop step and a restart step. Both paths
// then record and select A. An output stall holds the microprogram; the output
// register can issue one command word per cycle while the output does not
// stall. The input stalls while the microprogram runs.
module looper_channel_sequencer
	import lcs_pkg::*;
#(
	parameter int CHANNELS = LCS_CHANNELS
) (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       in_valid,
	output logic            in_stall,
	input  wire logic [1:0] command,
	input  wire logic [4:0] midi_channel,
	input  wire logic [6:0] number,
	input  wire logic [6:0] value,
	output logic            out_valid,
	input  wire logic       out_stall,
	output logic [4:0]      loop_channel,
	output logic [2:0]      action,
	output logic            last
);

	localparam int JW = $clog2(CHANNELS);

	step_t              step_q;
	step_t              step_d;
	ctrl_word_t         cw;
	logic [JW-1:0]      j_q;
	logic [CHANNELS-1:0] mask_q;
	logic [3:0]         active_q;
	logic [3:0]         pending_q;
	logic               armed_q;

	logic               out_valid_q;
	logic [4:0]         loop_channel_q;
	action_t            action_q;
	logic               last_q;

	logic               in_acc;
	logic               pedal;
	logic               j_last;
	logic               j_hit;
	logic               emit_now;
	logic               out_free;
	logic               advance;
	action_t            act_d;
	logic [3:0]         ch_d;

	lcs_ucode_rom u_rom (
		.step (step_q),
		.word (cw)
	);

	// input decode
	assign in_stall = (step_q != STEP_IDLE);
	assign in_acc   = in_valid && !in_stall;
	assign pedal    = (command == CMD_CONTROL) && (number == CC_SUSTAIN) && (value != 7'd0);

	// scan datapath conditions
	assign j_last = (j_q == JW'(CHANNELS - 1));
	assign j_hit  = mask_q[j_q];
	assign out_free = !out_valid_q || !out_stall;

	always_comb begin
		case (cw.emit)
			EMIT_MASK:       emit_now = j_hit;
			EMIT_MASK_OTHER: emit_now = j_hit && ({{(4 - JW){1'b0}}, j_q} != active_q);
			EMIT_ALWAYS:     emit_now = 1'b1;
			default:         emit_now = 1'b0;
		endcase
	end

	assign advance = !(emit_now && !out_free);

	// action and channel of the emitted word
	always_comb begin
		ch_d = {{(4 - JW){1'b0}}, j_q};
		case (cw.asel)
			ASEL_PLAY: begin
				if (j_q == JW'(HALF_CH))
					act_d = ACT_HALF;
				else if (j_q == JW'(REVERSE_CH))
					act_d = ACT_REVERSE;
				else
					act_d = ACT_PLAY;
			end
			ASEL_RECORD: begin
				act_d = ACT_RECORD;
				ch_d  = active_q;
			end
			ASEL_SELECT: begin
				act_d = ACT_SELECT_A;
				ch_d  = active_q;
			end
			default: act_d = ACT_STOP;
		endcase
	end

	// next step from the branch field
	always_comb begin
		step_d = step_q;
		unique case (cw.br)
			BR_NEXT: begin
				if (advance)
					step_d = cw.tgt_done;
			end
			BR_LOOP: begin
				if (advance)
					step_d = j_last ? cw.tgt_done : cw.tgt_more;
			end
			BR_DISPATCH: begin
				if (in_acc && pedal)
					step_d = armed_q ? STEP_RSCAN : STEP_STOP;
			end
			default: step_d = STEP_IDLE;
		endcase
	end

	// step counter
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			step_q <= STEP_IDLE;
		else
			step_q <= step_d;
	end

	// channel index, looping mask and event state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			j_q       <= '0;
			mask_q    <= '0;
			active_q  <= '0;
			pending_q <= '0;
			armed_q   <= 1'b0;
		end else begin
			if (advance && cw.inc_j)
				j_q <= j_last ? '0 : j_q + JW'(1);
			if (advance && (cw.op == OP_CLEAR)) begin
				mask_q  <= '0;
				armed_q <= 1'b0;
			end
			if (advance && (cw.op == OP_SET_ACTIVE))
				mask_q <= mask_q | (CHANNELS'(1) << active_q);
			if (in_acc && pedal)
				active_q <= pending_q;
			if (in_acc && (command == CMD_NOTE) && (midi_channel == MIDI_CH_CTRL)) begin
				if (number == NOTE_RESET)
					armed_q <= 1'b1;
				else if ((number >= NOTE_LOW) && (number < NOTE_HIGH))
					pending_q <= 4'(number - NOTE_LOW);
			end
		end
	end

	// output valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_valid_q <= 1'b0;
		else if (emit_now && out_free)
			out_valid_q <= 1'b1;
		else if (!out_stall)
			out_valid_q <= 1'b0;
	end

	// output word
	always_ff @(posedge clk) begin
		if (emit_now && out_free) begin
			loop_channel_q <= {1'b0, ch_d} + 5'd1;
			action_q       <= act_d;
			last_q         <= cw.last;
		end
	end

	assign out_valid    = out_valid_q;
	assign loop_channel = loop_channel_q;
	assign action       = action_q;
	assign last         = last_q;

	// checks
	`LCS_ASSERT_NOW(a_last_is_select, out_valid_q && last_q, action_q == ACT_SELECT_A,
		"final word of an event is not select A")
	`LCS_ASSERT_NEXT(a_pedal_starts, in_acc && pedal, step_q != STEP_IDLE,
		"pedal press did not start the microprogram")
	`LCS_ASSERT_NOW(a_record_marks, out_valid_q && (action_q == ACT_RECORD),
		((mask_q >> active_q) & CHANNELS'(1)) != '0,
		"recorded channel not marked as looping")
	`LCS_ASSERT_NEXT(a_clear_empties, (step_q == STEP_CLEAR), (mask_q == '0) && !armed_q,
		"reset pass left channels looping")

endmodule

`default_nettype wire
